@@ design/three_floor_elevator_controller_assert.svh @@
// ----------------------------------------------------------------------------
// three floor elevator controller assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef THREE_FLOOR_ELEVATOR_CONTROLLER_ASSERT_SVH
`define THREE_FLOOR_ELEVATOR_CONTROLLER_ASSERT_SVH

// same-cycle implication under reset
`define TFEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfec assertion failed");

// next-cycle implication under reset
`define TFEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfec assertion failed");

`endif

@@ design/tfec_pkg.sv @@
// ----------------------------------------------------------------------------
// tfec_pkg
// floor codes and status bit positions for the elevator controller
// ----------------------------------------------------------------------------
package tfec_pkg;

	typedef logic [1:0] floor_t;

	localparam floor_t FLOOR_NONE = 2'd0;
	localparam floor_t FLOOR_1    = 2'd1;
	localparam floor_t FLOOR_2    = 2'd2;
	localparam floor_t FLOOR_3    = 2'd3;

	// cabin status bits
	localparam int CAB_PERSON = 3;
	// hall status bits
	localparam int HALL_HEAVY  = 3;
	localparam int HALL_CLOSED = 4;
	// drive status bits
	localparam int DRV_MOVING = 3;
	localparam int DRV_EMERG  = 4;
	localparam int DRV_FIRE   = 5;
	localparam int DRV_ARRIVE = 6;

	// cabin command bits
	localparam int CMD_HEAVY  = 3;
	localparam int CMD_FIRE   = 4;
	localparam int CMD_EMERG  = 5;
	localparam int CMD_MOVING = 6;
	localparam int CMD_CLOSED = 7;

	// lowest pressed floor wins, none keeps the old request
	function automatic floor_t decode_low(input logic [2:0] btn, input floor_t keep);
		floor_t f;
		if (btn[0]) f = FLOOR_1;
		else if (btn[1]) f = FLOOR_2;
		else if (btn[2]) f = FLOOR_3;
		else f = keep;
		return f;
	endfunction

	// highest sensed floor wins, none keeps the old floor
	function automatic floor_t decode_high(input logic [2:0] sns, input floor_t keep);
		floor_t f;
		if (sns[2]) f = FLOOR_3;
		else if (sns[1]) f = FLOOR_2;
		else if (sns[0]) f = FLOOR_1;
		else f = keep;
		return f;
	endfunction

	function automatic logic [2:0] floor_onehot(input floor_t f);
		logic [2:0] oh;
		case (f)
			FLOOR_3: oh = 3'b100;
			FLOOR_2: oh = 3'b010;
			default: oh = 3'b001;
		endcase
		return oh;
	endfunction

endpackage

@@ design/three_floor_elevator_controller.sv @@
// ----------------------------------------------------------------------------
// three floor elevator controller
// path: an accepted item is held in the input register, then its commands go to the result register
// throughput: one item per cycle while results are taken; state updates only when an item advances
// result register decouples sides; one new item can enter the input register while a result waits
// reset: async active low; no requests, floor one, latch and motor bits clear
// ----------------------------------------------------------------------------
module three_floor_elevator_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] cabin_status,
	input  logic [7:0] hall_status,
	input  logic [7:0] drive_status,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cabin_command,
	output logic [3:0] hall_command,
	output logic [2:0] motor_command,
	output logic       alarm_lamp
);

	// input stage
	logic       valid_s1;
	logic [7:0] cabin_s1;
	logic [7:0] hall_s1;
	logic [7:0] drive_s1;

	// controller state
	tfec_pkg::floor_t cabin_req_q;
	tfec_pkg::floor_t hall_req_q;
	tfec_pkg::floor_t floor_q;
	logic             emerg_q;
	logic [2:0]       motor_q;

	// result register
	logic       out_valid_q;
	logic [7:0] cabin_cmd_q;
	logic [3:0] hall_cmd_q;

	logic advance;

	// next values
	tfec_pkg::floor_t cabin_req_d;
	tfec_pkg::floor_t hall_req_d;
	tfec_pkg::floor_t floor_d;
	logic             emerg_d;
	logic [2:0]       motor_d;
	logic [7:0]       cabin_cmd_d;
	logic [3:0]       hall_cmd_d;

	logic person, heavy, closed, moving, fire, arrive, pending, go;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		person  = cabin_s1[tfec_pkg::CAB_PERSON];
		heavy   = hall_s1[tfec_pkg::HALL_HEAVY];
		closed  = hall_s1[tfec_pkg::HALL_CLOSED];
		moving  = drive_s1[tfec_pkg::DRV_MOVING];
		fire    = drive_s1[tfec_pkg::DRV_FIRE];
		arrive  = drive_s1[tfec_pkg::DRV_ARRIVE];

		cabin_req_d = tfec_pkg::decode_low(cabin_s1[2:0], cabin_req_q);
		hall_req_d  = tfec_pkg::decode_low(hall_s1[2:0], hall_req_q);
		floor_d     = tfec_pkg::decode_high(drive_s1[2:0], floor_q);
		emerg_d     = emerg_q ^ drive_s1[tfec_pkg::DRV_EMERG];

		cabin_cmd_d = {closed, moving, emerg_d, fire, heavy, tfec_pkg::floor_onehot(floor_d)};

		pending    = (cabin_req_d != tfec_pkg::FLOOR_NONE) || (hall_req_d != tfec_pkg::FLOOR_NONE);
		hall_cmd_d = {pending && !closed, person,
			emerg_d || arrive || fire || (person && !moving), moving};

		// stopped at a requested floor
		if (!moving) begin
			if (cabin_req_d == floor_d) cabin_req_d = tfec_pkg::FLOOR_NONE;
			if (hall_req_d == floor_d) hall_req_d = tfec_pkg::FLOOR_NONE;
		end

		go = !person && !heavy && !fire && !emerg_d &&
			((cabin_req_d != tfec_pkg::FLOOR_NONE) || (hall_req_d != tfec_pkg::FLOOR_NONE));

		motor_d = motor_q;
		if (go) begin
			if (floor_d == tfec_pkg::FLOOR_2) begin
				if (cabin_req_d == tfec_pkg::FLOOR_1) begin
					motor_d[0]  = 1'b1;
					cabin_req_d = tfec_pkg::FLOOR_NONE;
				end else if (cabin_req_d == tfec_pkg::FLOOR_3) begin
					motor_d[2]  = 1'b1;
					cabin_req_d = tfec_pkg::FLOOR_NONE;
				end else if (hall_req_d == tfec_pkg::FLOOR_3) begin
					motor_d[2] = 1'b1;
					hall_req_d = tfec_pkg::FLOOR_NONE;
				end else if (hall_req_d == tfec_pkg::FLOOR_1) begin
					motor_d[0] = 1'b1;
					hall_req_d = tfec_pkg::FLOOR_NONE;
				end
			end else if (hall_req_d == tfec_pkg::FLOOR_2 || cabin_req_d == tfec_pkg::FLOOR_2) begin
				motor_d[1] = 1'b1;
				if (cabin_req_d == tfec_pkg::FLOOR_2) cabin_req_d = tfec_pkg::FLOOR_NONE;
				if (hall_req_d == tfec_pkg::FLOOR_2) hall_req_d = tfec_pkg::FLOOR_NONE;
			end else if (floor_d == tfec_pkg::FLOOR_1) begin
				motor_d[2] = 1'b1;
				if (cabin_req_d == tfec_pkg::FLOOR_3) cabin_req_d = tfec_pkg::FLOOR_NONE;
				if (hall_req_d == tfec_pkg::FLOOR_3) hall_req_d = tfec_pkg::FLOOR_NONE;
			end else begin
				motor_d[0] = 1'b1;
				if (cabin_req_d == tfec_pkg::FLOOR_1) cabin_req_d = tfec_pkg::FLOOR_NONE;
				if (hall_req_d == tfec_pkg::FLOOR_1) hall_req_d = tfec_pkg::FLOOR_NONE;
			end
		end else begin
			motor_d = 3'b000;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cabin_s1 <= cabin_status;
			hall_s1  <= hall_status;
			drive_s1 <= drive_status;
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cabin_req_q <= tfec_pkg::FLOOR_NONE;
			hall_req_q  <= tfec_pkg::FLOOR_NONE;
			floor_q     <= tfec_pkg::FLOOR_1;
			emerg_q     <= 1'b0;
			motor_q     <= 3'b000;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			cabin_req_q <= cabin_req_d;
			hall_req_q  <= hall_req_d;
			floor_q     <= floor_d;
			emerg_q     <= emerg_d;
			motor_q     <= motor_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cabin_cmd_q <= cabin_cmd_d;
			hall_cmd_q  <= hall_cmd_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign cabin_command = cabin_cmd_q;
	assign hall_command  = hall_cmd_q;
	assign motor_command = motor_q;
	assign alarm_lamp    = emerg_q;

endmodule

@@ design/tfec_checker.sv @@
// ----------------------------------------------------------------------------
// tfec_checker
// port level checks for the elevator controller, bound to the top level
// ----------------------------------------------------------------------------
`include "three_floor_elevator_controller_assert.svh"

module tfec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] cabin_command,
	input logic [3:0] hall_command,
	input logic [2:0] motor_command,
	input logic       alarm_lamp
);

	logic [15:0] result_bits;
	logic        flags_agree;
	logic        blocked;

	assign result_bits = {cabin_command, hall_command, motor_command, alarm_lamp};
	assign flags_agree = (alarm_lamp == cabin_command[tfec_pkg::CMD_EMERG]) &&
		(hall_command[0] == cabin_command[tfec_pkg::CMD_MOVING]);
	assign blocked = cabin_command[tfec_pkg::CMD_HEAVY] || cabin_command[tfec_pkg::CMD_FIRE] ||
		cabin_command[tfec_pkg::CMD_EMERG] || hall_command[2];

	// stalled result holds
	`TFEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_bits))

	// floor indicator is one-hot
	`TFEC_ASSERT_NOW(a_floor_onehot, clk, arst_n, out_valid, $onehot(cabin_command[2:0]))

	// lamp and moving flags agree across commands
	`TFEC_ASSERT_NOW(a_flags_agree, clk, arst_n, out_valid, flags_agree)

	// any blocking condition stops the motor
	`TFEC_ASSERT_NOW(a_motor_blocked, clk, arst_n, out_valid && blocked, motor_command == 3'b000)

endmodule

bind three_floor_elevator_controller tfec_checker u_tfec_checker (.*);

@@ tb/three_floor_elevator_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three floor elevator controller testbench
// poll rounds go in from a queue through a falling-edge driver; every accepted
// round advances a local copy of the controller state and queues the command
// set it should produce; a rising-edge monitor checks each result in order;
// both sides pause in random bursts, and the result side once stalls long
// enough to back up the input
// ----------------------------------------------------------------------------
module three_floor_elevator_controller_tb;

	typedef struct packed {
		logic [7:0] cab;
		logic [7:0] hall;
		logic [7:0] drv;
	} poll_t;

	typedef struct packed {
		logic [7:0] cabin;
		logic [3:0] hall;
		logic [2:0] motor;
		logic       lamp;
	} command_t;

	localparam logic [2:0] GO_FLOOR_1 = 3'b001;
	localparam logic [2:0] GO_FLOOR_2 = 3'b010;
	localparam logic [2:0] GO_FLOOR_3 = 3'b100;
	localparam int RANDOM_ROUNDS = 1130;
	localparam int QUIET_TAIL = 100;
	localparam int HOLD_CYCLES = 80;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] cabin_status = 8'h00;
	logic [7:0] hall_status = 8'h00;
	logic [7:0] drive_status = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] cabin_command;
	logic [3:0] hall_command;
	logic [2:0] motor_command;
	logic       alarm_lamp;

	poll_t    pending_rounds[$];
	command_t expected_cmds[$];

	// controller state as predicted
	tfec_pkg::floor_t cab_req = tfec_pkg::FLOOR_NONE;
	tfec_pkg::floor_t hall_req = tfec_pkg::FLOOR_NONE;
	tfec_pkg::floor_t cur_floor = tfec_pkg::FLOOR_1;
	logic             alarm_latch = 1'b0;
	logic [2:0]       motor_state = 3'b000;

	int  errors = 0;
	int  rounds_total = 0;
	int  rounds_taken = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  in_taken = 1'b0;
	bit  ready_hold = 1'b0;
	bit  quiet;

	three_floor_elevator_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cabin_status(cabin_status),
		.hall_status(hall_status),
		.drive_status(drive_status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cabin_command(cabin_command),
		.hall_command(hall_command),
		.motor_command(motor_command),
		.alarm_lamp(alarm_lamp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	task automatic drop_requests_at(input tfec_pkg::floor_t f);
		if (cab_req == f) cab_req = tfec_pkg::FLOOR_NONE;
		if (hall_req == f) hall_req = tfec_pkg::FLOOR_NONE;
	endtask

	task automatic advance_controller(input logic [7:0] cab, input logic [7:0] hall,
			input logic [7:0] drv);
		logic person, heavy, closed, moving, fire, arrive, emerg, pending;
		command_t c;
		if (cab[0]) cab_req = tfec_pkg::FLOOR_1;
		else if (cab[1]) cab_req = tfec_pkg::FLOOR_2;
		else if (cab[2]) cab_req = tfec_pkg::FLOOR_3;
		person = cab[tfec_pkg::CAB_PERSON];
		if (hall[0]) hall_req = tfec_pkg::FLOOR_1;
		else if (hall[1]) hall_req = tfec_pkg::FLOOR_2;
		else if (hall[2]) hall_req = tfec_pkg::FLOOR_3;
		heavy = hall[tfec_pkg::HALL_HEAVY];
		closed = hall[tfec_pkg::HALL_CLOSED];
		if (drv[2]) cur_floor = tfec_pkg::FLOOR_3;
		else if (drv[1]) cur_floor = tfec_pkg::FLOOR_2;
		else if (drv[0]) cur_floor = tfec_pkg::FLOOR_1;
		moving = drv[tfec_pkg::DRV_MOVING];
		if (drv[tfec_pkg::DRV_EMERG]) alarm_latch = ~alarm_latch;
		fire = drv[tfec_pkg::DRV_FIRE];
		arrive = drv[tfec_pkg::DRV_ARRIVE];
		emerg = alarm_latch;

		c.cabin = 8'h00;
		c.cabin[2:0] = (cur_floor == tfec_pkg::FLOOR_3) ? GO_FLOOR_3 :
			(cur_floor == tfec_pkg::FLOOR_2) ? GO_FLOOR_2 : GO_FLOOR_1;
		c.cabin[tfec_pkg::CMD_HEAVY] = heavy;
		c.cabin[tfec_pkg::CMD_FIRE] = fire;
		c.cabin[tfec_pkg::CMD_EMERG] = emerg;
		c.cabin[tfec_pkg::CMD_MOVING] = moving;
		c.cabin[tfec_pkg::CMD_CLOSED] = closed;
		pending = (cab_req != tfec_pkg::FLOOR_NONE) || (hall_req != tfec_pkg::FLOOR_NONE);
		c.hall = {pending && !closed, person, emerg || arrive || fire || (person && !moving),
			moving};

		if (!moving) drop_requests_at(cur_floor);
		pending = (cab_req != tfec_pkg::FLOOR_NONE) || (hall_req != tfec_pkg::FLOOR_NONE);
		if (!person && pending && !heavy && !fire && !emerg) begin
			if (cur_floor == tfec_pkg::FLOOR_2) begin
				if (cab_req == tfec_pkg::FLOOR_1) begin
					motor_state |= GO_FLOOR_1;
					cab_req = tfec_pkg::FLOOR_NONE;
				end else if (cab_req == tfec_pkg::FLOOR_3) begin
					motor_state |= GO_FLOOR_3;
					cab_req = tfec_pkg::FLOOR_NONE;
				end else if (hall_req == tfec_pkg::FLOOR_3) begin
					motor_state |= GO_FLOOR_3;
					hall_req = tfec_pkg::FLOOR_NONE;
				end else if (hall_req == tfec_pkg::FLOOR_1) begin
					motor_state |= GO_FLOOR_1;
					hall_req = tfec_pkg::FLOOR_NONE;
				end
			end else if (hall_req == tfec_pkg::FLOOR_2 || cab_req == tfec_pkg::FLOOR_2) begin
				motor_state |= GO_FLOOR_2;
				drop_requests_at(tfec_pkg::FLOOR_2);
			end else if (cur_floor == tfec_pkg::FLOOR_1) begin
				motor_state |= GO_FLOOR_3;
				drop_requests_at(tfec_pkg::FLOOR_3);
			end else begin
				motor_state |= GO_FLOOR_1;
				drop_requests_at(tfec_pkg::FLOOR_1);
			end
		end else begin
			motor_state = 3'b000;
		end
		c.motor = motor_state;
		c.lamp = alarm_latch;
		expected_cmds.push_back(c);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic add_round(input logic [7:0] cab, input logic [7:0] hall,
			input logic [7:0] drv);
		poll_t p;
		p.cab = cab;
		p.hall = hall;
		p.drv = drv;
		pending_rounds.push_back(p);
	endtask

	function automatic poll_t random_round();
		poll_t p;
		if (chance(15)) begin
			p = 24'($urandom());
		end else begin
			p.cab = {4'($urandom_range(15, 0)), chance(15), chance(25), chance(25), chance(25)};
			p.hall = {3'($urandom_range(7, 0)), chance(50), chance(8), chance(25), chance(25),
				chance(25)};
			p.drv = {1'($urandom_range(1, 0)), chance(30), chance(8), chance(4), chance(35),
				chance(30), chance(30), chance(30)};
		end
		return p;
	endfunction

	assign quiet = rounds_taken >= rounds_total - QUIET_TAIL;

	// driver
	always @(negedge clk) begin : drive_rounds
		logic  v;
		poll_t p;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			v = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_rounds.size() > 0 && !quiet && !ready_hold && chance(12)) begin
				send_gap = $urandom_range(7, 1) - 1;
			end else if (pending_rounds.size() > 0) begin
				p = pending_rounds.pop_front();
				v = 1'b1;
				cabin_status <= p.cab;
				hall_status <= p.hall;
				drive_status <= p.drv;
			end
			in_valid <= v;
		end
	end

	// result side pacing
	always @(negedge clk) begin : drain_results
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (ready_hold) begin
				out_ready <= 1'b0;
			end else if (!quiet && chance(15)) begin
				recv_gap = $urandom_range(7, 1) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long stall on the result side while items keep coming
	initial begin
		wait (rounds_taken >= 300);
		@(posedge clk);
		ready_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		ready_hold = 1'b0;
	end

	// monitor
	always @(posedge clk) begin : watch_ports
		command_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					flag_mismatch("unexpected item", int'({cabin_command, hall_command,
						motor_command, alarm_lamp}), 0);
				end else begin
					want = expected_cmds.pop_front();
					if (cabin_command !== want.cabin)
						flag_mismatch("cabin_command", int'(cabin_command), int'(want.cabin));
					if (hall_command !== want.hall)
						flag_mismatch("hall_command", int'(hall_command), int'(want.hall));
					if (motor_command !== want.motor)
						flag_mismatch("motor_command", int'(motor_command), int'(want.motor));
					if (alarm_lamp !== want.lamp)
						flag_mismatch("alarm_lamp", int'(alarm_lamp), int'(want.lamp));
				end
			end
			if (in_valid && in_ready) begin
				advance_controller(cabin_status, hall_status, drive_status);
				rounds_taken++;
				in_taken = 1'b1;
			end
		end
	end

	initial begin
		#2_400_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		// directed rounds
		add_round(8'h00, 8'h00, 8'h00);
		add_round(8'h07, 8'h00, 8'h07);
		add_round(8'h00, 8'h06, 8'h01);
		add_round(8'h06, 8'h00, 8'h03);
		add_round(8'h01, 8'h00, 8'h09);
		add_round(8'h00, 8'h04, 8'h0c);
		add_round(8'h02, 8'h00, 8'h0a);
		add_round(8'h01, 8'h04, 8'h02);
		add_round(8'h04, 8'h01, 8'h02);
		add_round(8'h00, 8'h05, 8'h02);
		add_round(8'h08, 8'h01, 8'h01);
		add_round(8'h02, 8'h08, 8'h04);
		add_round(8'h01, 8'h00, 8'h20);
		add_round(8'h04, 8'h00, 8'h10);
		add_round(8'h04, 8'h00, 8'h00);
		add_round(8'h04, 8'h00, 8'h10);
		add_round(8'h02, 8'h10, 8'h40);
		add_round(8'h0a, 8'h00, 8'h08);
		add_round(8'hff, 8'hff, 8'hff);
		add_round(8'hff, 8'hff, 8'hff);
		add_round(8'hf0, 8'he0, 8'h80);
		add_round(8'h00, 8'h00, 8'h00);
		repeat (RANDOM_ROUNDS) pending_rounds.push_back(random_round());
		rounds_total = pending_rounds.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_rounds.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ three_floor_elevator_controller.f @@
+incdir+design
design/tfec_pkg.sv
design/three_floor_elevator_controller.sv
design/tfec_checker.sv
tb/three_floor_elevator_controller_tb.sv
